// ===== src/assert_macros.svh =====
// assertion helpers shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge out of reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ssdt_pkg.sv =====
package ssdt_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int MAX_RES = 16;
  localparam int OP_W = 4;
  localparam int KEY_W = 64;
  localparam int SEQ_W = 64;
  localparam int TIME_W = 32;
  localparam int EXP_W = 31;
  localparam int CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK_DUP   = 4'd0,
    OP_PUT         = 4'd1,
    OP_TOUCH       = 4'd2,
    OP_REMOVE      = 4'd3,
    OP_COLLECT     = 4'd4,
    OP_CLEAR_ACKED = 4'd5,
    OP_EXPIRE      = 4'd6,
    OP_CLEAR_ALL   = 4'd7,
    OP_TICK        = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_OUT
  } state_t;

  // result item
  typedef struct packed {
    logic              flag;
    logic              table_full;
    logic [CNT_W-1:0]  count;
    logic [KEY_W-1:0]  client_key;
    logic [KEY_W-1:0]  thread_id;
    logic [SEQ_W-1:0]  seq;
    logic              last;
  } result_t;

  // compare results of the shared unit for one slot
  typedef struct packed {
    logic key_eq;
    logic seq_le;
    logic expired;
  } cmp_t;

endpackage

// ===== src/source_sequence_dedup_table.sv =====
// Sequencer-driven dedup table of ENTRIES slots keyed by (client_key,
// thread_id). Each request is taken when in_tready is high, then the slots
// are visited one per cycle through a single compare unit, with the walk
// held while a collect entry waits in the output. A keyed request or an
// expire passes through the scan, execute and output states, while
// clear_all, tick and an unknown op skip the scan. The next request is
// taken in the cycle after the last result is accepted. collect_unacked
// walks the slots up to and including the last one it emits, and outputs
// each emitted entry as it is found; with nothing to emit it walks all
// slots and returns one result like a keyed request. Cycles with out_tready
// low hold the output state. The table is empty after reset; no clearing
// pass is needed.
module source_sequence_dedup_table #(
  parameter int ENTRIES = ssdt_pkg::ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[3:0], client_key[67:4], thread_id[131:68], seq[195:132],
  // only_new[196], only_acked[197], zero fill up to 199
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // flag[0], table_full[1], count[6:2], out_client_key[70:7],
  // out_thread_id[134:71], out_seq[198:135], zero fill 199
  output logic [199:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data
);
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CTR_W = $clog2(ENTRIES + 1);

  ssdt_pkg::state_t state_r, state_nxt;

  // slot store
  logic [ENTRIES-1:0]           valid_r, acked_r;
  logic [ssdt_pkg::KEY_W-1:0]   ent_client [ENTRIES];
  logic [ssdt_pkg::KEY_W-1:0]   ent_thread [ENTRIES];
  logic [ssdt_pkg::SEQ_W-1:0]   ent_seq    [ENTRIES];
  logic [ssdt_pkg::TIME_W-1:0]  ent_dl     [ENTRIES];

  logic [ssdt_pkg::TIME_W-1:0]  now_r;
  logic [ssdt_pkg::EXP_W-1:0]   expiry_r;

  // request registers
  logic [ssdt_pkg::OP_W-1:0]    op_r;
  logic [ssdt_pkg::KEY_W-1:0]   ck_r, th_r;
  logic [ssdt_pkg::SEQ_W-1:0]   sq_r;
  logic                         only_new_r, only_acked_r;

  // scan bookkeeping
  logic [CTR_W-1:0]             idx_r;
  logic                         hit_r, hit_le_r, free_r;
  logic [IDX_W-1:0]             hit_idx_r, free_idx_r;
  logic [ssdt_pkg::CNT_W-1:0]   cnt_r, emitted_r;

  ssdt_pkg::result_t            res_r;
  logic                         out_v_r;

  logic [IDX_W-1:0]             cur;
  ssdt_pkg::cmp_t               cmp;
  logic [ssdt_pkg::TIME_W-1:0]  new_dl;
  logic                         scan_done;
  logic                         in_acc, out_acc;
  logic                         emit_now, more_pending;
  ssdt_pkg::result_t            emit_res, exec_res;

  assign cur       = idx_r[IDX_W-1:0];
  assign new_dl    = now_r + {1'b0, expiry_r};
  assign scan_done = (idx_r == CTR_W'(ENTRIES - 1));
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_v_r && out_tready;
  assign cfg_ready = 1'b1;

  ssdt_cmp u_cmp (
    .a_client (ck_r),
    .a_thread (th_r),
    .a_seq    (sq_r),
    .b_client (ent_client[cur]),
    .b_thread (ent_thread[cur]),
    .b_seq    (ent_seq[cur]),
    .deadline (ent_dl[cur]),
    .now      (now_r),
    .res      (cmp)
  );

  // collect: the current slot is emitted when unacked and valid and fewer than MAX_RES were emitted
  assign emit_now = (op_r == ssdt_pkg::OP_COLLECT) && valid_r[cur] && !acked_r[cur]
                    && (emitted_r < ssdt_pkg::CNT_W'(ssdt_pkg::MAX_RES));
  // is there any further emittable slot past cur
  always_comb begin
    more_pending = 1'b0;
    for (int i = 0; i < ENTRIES; i++)
      if (i > int'(cur) && valid_r[i] && !acked_r[i]) more_pending = 1'b1;
    if (emitted_r + 5'd1 >= ssdt_pkg::CNT_W'(ssdt_pkg::MAX_RES)) more_pending = 1'b0;
  end

  // result of an emitted collect entry
  always_comb begin
    emit_res            = '0;
    emit_res.flag       = 1'b1;
    emit_res.client_key = ent_client[cur];
    emit_res.thread_id  = ent_thread[cur];
    emit_res.seq        = ent_seq[cur];
    emit_res.last       = scan_done || !more_pending;
  end

  // single result of the execute step
  always_comb begin
    exec_res      = '0;
    exec_res.last = 1'b1;
    case (op_r)
      ssdt_pkg::OP_CHECK_DUP: exec_res.flag = hit_r && hit_le_r;
      ssdt_pkg::OP_PUT: begin
        if (hit_r) exec_res.flag = !(only_new_r && hit_le_r);
        else if (free_r) exec_res.flag = 1'b1;
        else exec_res.table_full = 1'b1;
      end
      ssdt_pkg::OP_TOUCH: exec_res.flag = hit_r;
      ssdt_pkg::OP_REMOVE: exec_res.flag = hit_r;
      ssdt_pkg::OP_CLEAR_ACKED: exec_res.flag = hit_r;
      ssdt_pkg::OP_EXPIRE: begin
        exec_res.count = cnt_r;
        exec_res.flag  = (cnt_r != '0);
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssdt_pkg::ST_IDLE: if (in_acc) begin
        if (in_tdata[3:0] == ssdt_pkg::OP_CLEAR_ALL || in_tdata[3:0] == ssdt_pkg::OP_TICK
            || in_tdata[3:0] > ssdt_pkg::OP_TICK)
          state_nxt = ssdt_pkg::ST_EXEC;
        else
          state_nxt = ssdt_pkg::ST_SCAN;
      end
      ssdt_pkg::ST_SCAN: begin
        if (emit_now) state_nxt = ssdt_pkg::ST_OUT;
        else if (scan_done) state_nxt = ssdt_pkg::ST_EXEC;
      end
      ssdt_pkg::ST_EXEC: state_nxt = ssdt_pkg::ST_OUT;
      ssdt_pkg::ST_OUT: if (out_acc) begin
        if (res_r.last) state_nxt = ssdt_pkg::ST_IDLE;
        else state_nxt = ssdt_pkg::ST_SCAN;
      end
      default: state_nxt = ssdt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == ssdt_pkg::ST_IDLE);
    out_tvalid = out_v_r;
    out_tlast  = res_r.last;
    out_tdata  = {1'b0, res_r.seq, res_r.thread_id, res_r.client_key, res_r.count,
                  res_r.table_full, res_r.flag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ssdt_pkg::ST_IDLE;
      valid_r  <= '0;
      acked_r  <= '0;
      now_r    <= '0;
      expiry_r <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) expiry_r <= cfg_data;
      if (out_acc) out_v_r <= 1'b0;

      unique case (state_r)
        ssdt_pkg::ST_IDLE: if (in_acc) begin
          op_r         <= in_tdata[3:0];
          ck_r         <= in_tdata[67:4];
          th_r         <= in_tdata[131:68];
          sq_r         <= in_tdata[195:132];
          only_new_r   <= in_tdata[196];
          only_acked_r <= in_tdata[197];
          idx_r        <= '0;
          hit_r        <= 1'b0;
          hit_le_r     <= 1'b0;
          free_r       <= 1'b0;
          hit_idx_r    <= '0;
          free_idx_r   <= '0;
          cnt_r        <= '0;
          emitted_r    <= '0;
        end
        ssdt_pkg::ST_SCAN: begin
          if (!scan_done) idx_r <= idx_r + 1'b1;
          // key search, first match wins
          if (valid_r[cur] && cmp.key_eq && !hit_r) begin
            hit_r     <= 1'b1;
            hit_le_r  <= cmp.seq_le;
            hit_idx_r <= cur;
          end
          if (!valid_r[cur] && !free_r) begin
            free_r     <= 1'b1;
            free_idx_r <= cur;
          end
          // expire sweep
          if (op_r == ssdt_pkg::OP_EXPIRE && valid_r[cur] && cmp.expired
              && (!only_acked_r || acked_r[cur])) begin
            valid_r[cur] <= 1'b0;
            acked_r[cur] <= 1'b0;
            if (cnt_r != 5'd31) cnt_r <= cnt_r + 1'b1;
          end
          if (emit_now) begin
            acked_r[cur] <= 1'b1;
            emitted_r    <= emitted_r + 1'b1;
            out_v_r      <= 1'b1;
            res_r        <= emit_res;
          end
        end
        ssdt_pkg::ST_EXEC: begin
          out_v_r <= 1'b1;
          res_r   <= exec_res;
          case (op_r)
            ssdt_pkg::OP_PUT: begin
              if (hit_r) begin
                if (!(only_new_r && hit_le_r)) acked_r[hit_idx_r] <= 1'b0;
              end else if (free_r) begin
                valid_r[free_idx_r] <= 1'b1;
                acked_r[free_idx_r] <= 1'b0;
              end
            end
            ssdt_pkg::OP_REMOVE: begin
              if (hit_r) begin
                valid_r[hit_idx_r] <= 1'b0;
                acked_r[hit_idx_r] <= 1'b0;
              end
            end
            ssdt_pkg::OP_CLEAR_ACKED: begin
              if (hit_r) acked_r[hit_idx_r] <= 1'b0;
            end
            ssdt_pkg::OP_CLEAR_ALL: begin
              valid_r <= '0;
              acked_r <= '0;
            end
            ssdt_pkg::OP_TICK: now_r <= now_r + 1'b1;
            default: ;
          endcase
        end
        ssdt_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  // slot payload store
  always_ff @(posedge clk) begin
    if (state_r == ssdt_pkg::ST_EXEC) begin
      if (op_r == ssdt_pkg::OP_PUT) begin
        if (hit_r && !(only_new_r && hit_le_r)) begin
          ent_seq[hit_idx_r] <= sq_r;
          ent_dl[hit_idx_r]  <= new_dl;
        end else if (!hit_r && free_r) begin
          ent_client[free_idx_r] <= ck_r;
          ent_thread[free_idx_r] <= th_r;
          ent_seq[free_idx_r]    <= sq_r;
          ent_dl[free_idx_r]     <= new_dl;
        end
      end else if (op_r == ssdt_pkg::OP_TOUCH && hit_r) begin
        ent_dl[hit_idx_r] <= new_dl;
      end
    end
  end
endmodule

// ===== src/ssdt_cmp.sv =====
// shared compare unit: key match, signed sequence order, deadline test
module ssdt_cmp (
  input  logic [ssdt_pkg::KEY_W-1:0]  a_client,
  input  logic [ssdt_pkg::KEY_W-1:0]  a_thread,
  input  logic [ssdt_pkg::SEQ_W-1:0]  a_seq,
  input  logic [ssdt_pkg::KEY_W-1:0]  b_client,
  input  logic [ssdt_pkg::KEY_W-1:0]  b_thread,
  input  logic [ssdt_pkg::SEQ_W-1:0]  b_seq,
  input  logic [ssdt_pkg::TIME_W-1:0] deadline,
  input  logic [ssdt_pkg::TIME_W-1:0] now,
  output ssdt_pkg::cmp_t              res
);
  logic [ssdt_pkg::TIME_W-1:0] diff;

  assign diff = deadline - now;

  always_comb begin
    res.key_eq  = (a_client == b_client) && (a_thread == b_thread);
    res.seq_le  = $signed(a_seq) <= $signed(b_seq);
    res.expired = diff[ssdt_pkg::TIME_W-1];
  end
endmodule

// ===== src/ssdt_checker.sv =====
`include "assert_macros.svh"

// port-level checks of the dedup table
module ssdt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata,
  input logic         out_tlast
);
  // no new request while a result is waiting
  `CHK_IMPL(a_busy_out, clk, rst_n, out_tvalid, !in_tready, "ready during result")
  // request accept drops ready next cycle
  `CHK_NEXT(a_drop_rdy, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready stayed")
  // stalled result holds
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
            "result changed under stall")
  // full flag only with flag clear and on the last result
  `CHK_IMPL(a_full, clk, rst_n, out_tvalid && out_tdata[1], !out_tdata[0] && out_tlast,
            "bad table_full")
endmodule

bind source_sequence_dedup_table ssdt_checker u_ssdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
